// File: rtl/grc_pkg.sv
// Shared types and constants for the plane-rotation chain block.
// Used by the front end, the item queue, the back end and the top level.
`default_nettype none

package grc_pkg;

  // Class of an accepted item, decided by the front end.
  typedef enum logic [1:0] {
    OP_LOAD      = 2'd0,  // first of a row: load the carry only
    OP_LOAD_EMIT = 2'd1,  // first and last together: load and emit unchanged
    OP_ROT       = 2'd2,  // rotate, emit one element
    OP_ROT_FLUSH = 2'd3   // rotate, emit one element and then the carry
  } op_t;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPW         = $clog2(QUEUE_DEPTH);
  localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

  localparam int OUT_DEPTH   = 4;
  localparam int OPW         = $clog2(OUT_DEPTH);
  localparam int OCW         = $clog2(OUT_DEPTH + 1);

  // Status of the back end, watched by the checks in the top level.
  typedef struct packed {
    logic [OCW-1:0] ocount;   // results held in the output buffer
    logic [1:0]     pushes;   // results written this cycle
    logic           q_pop;    // an item taken from the queue this cycle
    logic           out_pop;  // a result taken by the receiver this cycle
  } back_status_t;

endpackage

`default_nettype wire

// File: rtl/givens_rotation_chain_core.sv
// Plane-rotation chain: applies a chain of Givens rotations to a streamed row.
// Channels: input items (element, cosine, sine, first, last) on in_valid and
// in_stall; results (value, last) on out_valid and out_stall; the direction
// register is written on cfg_valid/cfg_ready (ready is always high); the user
// must write it only while the block is idle, and the block does not enforce
// it. Direction 0 sweeps in index order, 1 in reverse. A first item only loads
// the carry (it is emitted at once when it is also last). Every other item
// gives one rotated element, and a last item also gives the final carry,
// flagged by out_result_last. An accepted item waits in the item queue until
// two result slots are free in the output buffer; its results are then
// written there, a final carry in the entry behind its element.
// Throughput: one item per cycle while the output buffer has room; a last item
// gives two results. The rate is set by the carry loop, where two multiplies,
// an add and saturation feed the carry register combinationally.
// Reset (rst_n low, synchronous) empties the queue and the output buffer and
// clears the carry and direction. While the receiver stalls, results wait in
// a four-entry buffer and then in a two-entry item queue, after which
// in_stall rises; nothing is dropped.
// Depends on grc_pkg, grc_front, grc_queue and grc_back.
`default_nettype none

module givens_rotation_chain_core
  import grc_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int COEF_WIDTH = 18
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_valid,
  output      logic                         cfg_ready,
  input  wire logic                         cfg_direction,
  input  wire logic                         in_valid,
  output      logic                         in_stall,
  input  wire logic signed [DATA_WIDTH-1:0] in_element_value,
  input  wire logic signed [COEF_WIDTH-1:0] in_cosine,
  input  wire logic signed [COEF_WIDTH-1:0] in_sine,
  input  wire logic                         in_first,
  input  wire logic                         in_last,
  output      logic                         out_valid,
  input  wire logic                         out_stall,
  output      logic signed [DATA_WIDTH-1:0] out_result_value,
  output      logic                         out_result_last
);

  localparam int CX = COEF_WIDTH + 1;
  localparam int QW = $bits(op_t) + DATA_WIDTH + 3 * CX;

  logic                         f_push;
  op_t                          f_op;
  logic signed [DATA_WIDTH-1:0] f_elem;
  logic signed [CX-1:0]         f_cos;
  logic signed [CX-1:0]         f_coef_a;
  logic signed [CX-1:0]         f_coef_b;
  logic                         q_full;
  logic                         q_valid;
  logic                         q_pop;
  logic [QW-1:0]                q_data;
  op_t                          b_op;
  back_status_t                 b_status;

  grc_front #(
    .DATA_WIDTH(DATA_WIDTH),
    .COEF_WIDTH(COEF_WIDTH)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_direction   (cfg_direction),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_element_value(in_element_value),
    .in_cosine       (in_cosine),
    .in_sine         (in_sine),
    .in_first        (in_first),
    .in_last         (in_last),
    .q_full          (q_full),
    .q_push          (f_push),
    .q_op            (f_op),
    .q_elem          (f_elem),
    .q_cos           (f_cos),
    .q_coef_a        (f_coef_a),
    .q_coef_b        (f_coef_b)
  );

  grc_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (f_push),
    .push_data({f_op, f_elem, f_cos, f_coef_a, f_coef_b}),
    .full     (q_full),
    .pop_valid(q_valid),
    .pop_data (q_data),
    .pop      (q_pop)
  );

  assign b_op = op_t'(q_data[QW-1 -: $bits(op_t)]);

  grc_back #(
    .DATA_WIDTH(DATA_WIDTH),
    .COEF_WIDTH(COEF_WIDTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_pop           (q_pop),
    .q_op            (b_op),
    .q_elem          (q_data[3*CX +: DATA_WIDTH]),
    .q_cos           (q_data[2*CX +: CX]),
    .q_coef_a        (q_data[CX +: CX]),
    .q_coef_b        (q_data[0 +: CX]),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_value(out_result_value),
    .out_result_last (out_result_last),
    .status          (b_status)
  );

  // The output buffer never holds more than its depth.
  a_ocount_bound: assert property (@(posedge clk) disable iff (!rst_n)
    b_status.ocount <= OCW'(OUT_DEPTH))
    else $error("output buffer overfilled");

  // The buffer fill follows what was written and what the receiver took.
  a_ocount_track: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |->
      b_status.ocount == $past(b_status.ocount) + OCW'($past(b_status.pushes))
                         - OCW'($past(b_status.out_pop)))
    else $error("output buffer count lost track");

  // An item is only taken from the queue when two result slots are free.
  a_pop_room: assert property (@(posedge clk) disable iff (!rst_n)
    b_status.q_pop |-> (b_status.ocount <= OCW'(OUT_DEPTH - 2)))
    else $error("item taken without room for its results");

endmodule

`default_nettype wire

// File: rtl/grc_front.sv
// Front end: holds the direction register, accepts items and classifies them.
// Depends on grc_pkg; feeds grc_queue.
`default_nettype none

module grc_front
  import grc_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int COEF_WIDTH = 18
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_valid,
  output      logic                         cfg_ready,
  input  wire logic                         cfg_direction,
  input  wire logic                         in_valid,
  output      logic                         in_stall,
  input  wire logic signed [DATA_WIDTH-1:0] in_element_value,
  input  wire logic signed [COEF_WIDTH-1:0] in_cosine,
  input  wire logic signed [COEF_WIDTH-1:0] in_sine,
  input  wire logic                         in_first,
  input  wire logic                         in_last,
  input  wire logic                         q_full,
  output      logic                         q_push,
  output      op_t                          q_op,
  output      logic signed [DATA_WIDTH-1:0] q_elem,
  output      logic signed [COEF_WIDTH:0]   q_cos,
  output      logic signed [COEF_WIDTH:0]   q_coef_a,
  output      logic signed [COEF_WIDTH:0]   q_coef_b
);

  logic                       direction_r;
  logic signed [COEF_WIDTH:0] sine_x;
  logic signed [COEF_WIDTH:0] sine_neg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      direction_r <= cfg_direction;
    end
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    unique case ({in_first, in_last})
      2'b10:   q_op = OP_LOAD;
      2'b11:   q_op = OP_LOAD_EMIT;
      2'b00:   q_op = OP_ROT;
      default: q_op = OP_ROT_FLUSH;
    endcase
  end

  // One extra bit so that negating the most negative sine stays exact.
  assign sine_x   = {in_sine[COEF_WIDTH-1], in_sine};
  assign sine_neg = -sine_x;
  assign q_elem   = in_element_value;
  assign q_cos    = {in_cosine[COEF_WIDTH-1], in_cosine};

  // The emitted value pairs the element with coef_a, the new carry pairs the
  // old carry with coef_b; the direction only swaps which of them is negated.
  assign q_coef_a = direction_r ? sine_neg : sine_x;
  assign q_coef_b = direction_r ? sine_x : sine_neg;

endmodule

`default_nettype wire

// File: rtl/grc_queue.sv
// Short item queue between the front end and the back end.
// Depends on grc_pkg for its depth.
`default_nettype none

module grc_queue
  import grc_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output      logic             full,
  output      logic             pop_valid,
  output      logic [WIDTH-1:0] pop_data,
  input  wire logic             pop
);

  logic [WIDTH-1:0] mem_r [QUEUE_DEPTH];
  logic [QPW-1:0]   wr_ptr_r;
  logic [QPW-1:0]   rd_ptr_r;
  logic [QCW-1:0]   count_r;
  logic [QCW-1:0]   count_nxt;
  logic             do_pop;

  assign full      = (count_r == QCW'(QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_pop    = pop && pop_valid;

  always_comb begin
    count_nxt = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + QCW'(1);
    end else if (do_pop && !push) begin
      count_nxt = count_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPW'(1);
      end
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/grc_back.sv
// Back end: carry register, the four rounded products, saturation and the
// output buffer. Depends on grc_pkg; takes items from grc_queue.
`default_nettype none

module grc_back
  import grc_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int COEF_WIDTH = 18
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         q_valid,
  output      logic                         q_pop,
  input  wire op_t                          q_op,
  input  wire logic signed [DATA_WIDTH-1:0] q_elem,
  input  wire logic signed [COEF_WIDTH:0]   q_cos,
  input  wire logic signed [COEF_WIDTH:0]   q_coef_a,
  input  wire logic signed [COEF_WIDTH:0]   q_coef_b,
  output      logic                         out_valid,
  input  wire logic                         out_stall,
  output      logic signed [DATA_WIDTH-1:0] out_result_value,
  output      logic                         out_result_last,
  output      back_status_t                 status
);

  localparam int FRAC = COEF_WIDTH - 2;
  localparam int PW   = DATA_WIDTH + COEF_WIDTH + 1;
  localparam int RW   = PW - FRAC;
  localparam int SW   = RW + 1;
  localparam logic signed [SW-1:0] SMAX =
    $signed({{(SW - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}});
  localparam logic signed [SW-1:0] SMIN =
    $signed({{(SW - DATA_WIDTH + 1){1'b1}}, {(DATA_WIDTH - 1){1'b0}}});

  // Exact product, rounded to nearest with ties towards plus infinity.
  function automatic logic signed [RW-1:0] rnd_mul(
    input logic signed [DATA_WIDTH-1:0] a,
    input logic signed [COEF_WIDTH:0]   c
  );
    logic signed [PW-1:0] p;
    p = PW'(a) * PW'(c);
    p = p + (PW'(1) <<< (FRAC - 1));
    return RW'(p >>> FRAC);
  endfunction

  function automatic logic signed [DATA_WIDTH-1:0] sat_sum(
    input logic signed [RW-1:0] x,
    input logic signed [RW-1:0] y
  );
    logic signed [SW-1:0] s;
    s = SW'(x) + SW'(y);
    if (s > SMAX) begin
      return SMAX[DATA_WIDTH-1:0];
    end else if (s < SMIN) begin
      return SMIN[DATA_WIDTH-1:0];
    end
    return s[DATA_WIDTH-1:0];
  endfunction

  logic signed [DATA_WIDTH-1:0] carry_r;
  logic signed [DATA_WIDTH-1:0] done_val;
  logic signed [DATA_WIDTH-1:0] next_val;

  logic signed [DATA_WIDTH-1:0] res_val_r  [OUT_DEPTH];
  logic                         res_last_r [OUT_DEPTH];
  logic [OPW-1:0]               wr_ptr_r;
  logic [OPW-1:0]               rd_ptr_r;
  logic [OCW-1:0]               ocount_r;
  logic [OCW-1:0]               ocount_nxt;

  logic [1:0]                   n_res;
  logic [1:0]                   n_push;
  logic signed [DATA_WIDTH-1:0] d0_val;
  logic                         d0_last;
  logic                         out_pop;

  assign done_val = sat_sum(rnd_mul(carry_r, q_cos), rnd_mul(q_elem, q_coef_a));
  assign next_val = sat_sum(rnd_mul(carry_r, q_coef_b), rnd_mul(q_elem, q_cos));

  // An item is taken only while two result slots are free, so a flushing
  // item never has to be split across cycles.
  assign q_pop   = q_valid && (ocount_r <= OCW'(OUT_DEPTH - 2));
  assign out_valid        = (ocount_r != '0);
  assign out_pop          = out_valid && !out_stall;
  assign out_result_value = res_val_r[rd_ptr_r];
  assign out_result_last  = res_last_r[rd_ptr_r];

  always_comb begin
    unique case (q_op)
      OP_LOAD: begin
        n_res   = 2'd0;
        d0_val  = q_elem;
        d0_last = 1'b0;
      end
      OP_LOAD_EMIT: begin
        n_res   = 2'd1;
        d0_val  = q_elem;
        d0_last = 1'b1;
      end
      OP_ROT: begin
        n_res   = 2'd1;
        d0_val  = done_val;
        d0_last = 1'b0;
      end
      default: begin
        n_res   = 2'd2;
        d0_val  = done_val;
        d0_last = 1'b0;
      end
    endcase
    n_push     = q_pop ? n_res : 2'd0;
    ocount_nxt = ocount_r + OCW'(n_push) - OCW'(out_pop);
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      res_val_r[wr_ptr_r]  <= d0_val;
      res_last_r[wr_ptr_r] <= d0_last;
    end
    if (n_push == 2'd2) begin
      res_val_r[wr_ptr_r + OPW'(1)]  <= next_val;
      res_last_r[wr_ptr_r + OPW'(1)] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry_r  <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      ocount_r <= '0;
    end else begin
      if (q_pop) begin
        if (q_op == OP_LOAD || q_op == OP_LOAD_EMIT) begin
          carry_r <= q_elem;
        end else begin
          carry_r <= next_val;
        end
      end
      wr_ptr_r <= wr_ptr_r + OPW'(n_push);
      if (out_pop) begin
        rd_ptr_r <= rd_ptr_r + OPW'(1);
      end
      ocount_r <= ocount_nxt;
    end
  end

  assign status.ocount  = ocount_r;
  assign status.pushes  = n_push;
  assign status.q_pop   = q_pop;
  assign status.out_pop = out_pop;

endmodule

`default_nettype wire

// File: dv/tb_givens_rotation_chain_core.sv
// Self-checking testbench for givens_rotation_chain_core: streams rows of elements with
// cosine/sine pairs in both sweep directions and checks every rotated element and final carry.
// Depends only on the RTL of the block; it has its own bit-exact model of the rotation chain.
module tb_givens_rotation_chain_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW = 32;
  localparam int CW = 18;
  localparam int CF = CW - 2;
  localparam longint DATA_MAX = (longint'(1) <<< (DW - 1)) - 1;
  localparam longint DATA_MIN = -(longint'(1) <<< (DW - 1));

  localparam logic DIR_FORWARD  = 1'b0;
  localparam logic DIR_BACKWARD = 1'b1;

  localparam int HOLD_CYCLES = 60;
  localparam int TAIL_CYCLES = 8;
  localparam int DRAIN_LIMIT = 5000;
  localparam int PRINT_LIMIT = 100;

  typedef struct {
    logic [DW-1:0] element;
    logic [CW-1:0] cosine;
    logic [CW-1:0] sine;
    logic          first;
    logic          last;
  } row_item_t;

  typedef struct {
    logic [DW-1:0] value;
    logic          last;
  } row_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_direction = 1'b0;
  logic in_valid = 1'b0;
  logic signed [DW-1:0] in_element_value = '0;
  logic signed [CW-1:0] in_cosine = '0;
  logic signed [CW-1:0] in_sine = '0;
  logic in_first = 1'b0;
  logic in_last = 1'b0;
  logic out_stall = 1'b0;
  logic cfg_ready;
  logic in_stall;
  logic out_valid;
  logic signed [DW-1:0] out_result_value;
  logic out_result_last;

  // Stimulus side
  row_item_t row_stream[$];
  int n_queued = 0;
  int src_gap = 0;
  int src_idle_pct = 0;
  row_item_t next_item;

  // Model side
  row_result_t rotated_values_due[$];
  row_result_t want;
  logic signed [DW-1:0] chain_carry = '0;
  logic sweep_dir = DIR_FORWARD;
  int n_accepted = 0;
  int n_checked = 0;
  int n_rows = 0;
  int n_fwd = 0;
  int n_bwd = 0;
  int errors = 0;
  int sink_gap = 0;
  int sink_idle_pct = 0;

  // Long receiver hold-off
  logic hold_armed = 1'b0;
  logic long_hold = 1'b0;
  int hold_left = 0;

  givens_rotation_chain_core #(
    .DATA_WIDTH(DW),
    .COEF_WIDTH(CW)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_direction(cfg_direction),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_element_value(in_element_value),
    .in_cosine(in_cosine),
    .in_sine(in_sine),
    .in_first(in_first),
    .in_last(in_last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_result_value(out_result_value),
    .out_result_last(out_result_last)
  );

  always #5 clk = ~clk;

  // Exact product, rounded to nearest with ties going up.
  function automatic longint round_product(longint x, longint k);
    longint p;
    p = x * k;
    return (p + (longint'(1) <<< (CF - 1))) >>> CF;
  endfunction

  function automatic logic [DW-1:0] mix_terms(longint a, longint ka, longint b, longint kb);
    longint total;
    total = round_product(a, ka) + round_product(b, kb);
    if (total > DATA_MAX) return {1'b0, {(DW-1){1'b1}}};
    if (total < DATA_MIN) return {1'b1, {(DW-1){1'b0}}};
    return total[DW-1:0];
  endfunction

  task automatic rotate_into_chain(input logic signed [DW-1:0] elem,
                                   input logic signed [CW-1:0] c,
                                   input logic signed [CW-1:0] s,
                                   input logic first, input logic last);
    longint e, h, ck, sk;
    logic [DW-1:0] done;
    e = elem;
    h = chain_carry;
    ck = c;
    sk = s;
    if (first) begin
      chain_carry = elem;
      n_rows++;
      if (last) rotated_values_due.push_back('{elem, 1'b1});
    end else begin
      if (sweep_dir == DIR_FORWARD) begin
        done = mix_terms(h, ck, e, sk);
        chain_carry = mix_terms(h, -sk, e, ck);
        n_fwd++;
      end else begin
        done = mix_terms(e, -sk, h, ck);
        chain_carry = mix_terms(e, ck, h, sk);
        n_bwd++;
      end
      rotated_values_due.push_back('{done, 1'b0});
      if (last) rotated_values_due.push_back('{chain_carry, 1'b1});
    end
  endtask

  // Driver: offers queued items, holding the payload while the block stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      src_gap = 0;
    end else if (!in_valid || !in_stall) begin
      if (src_gap > 0) begin
        src_gap--;
        in_valid <= 1'b0;
      end else if (row_stream.size() != 0) begin
        next_item = row_stream.pop_front();
        in_valid <= 1'b1;
        in_element_value <= next_item.element;
        in_cosine <= next_item.cosine;
        in_sine <= next_item.sine;
        in_first <= next_item.first;
        in_last <= next_item.last;
        if (src_idle_pct != 0 && $urandom_range(1, 100) <= src_idle_pct)
          src_gap = $urandom_range(1, 5);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: tracks the register and accepted items, checks results and drives out_stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      sink_gap = 0;
    end else begin
      if (cfg_valid && cfg_ready) sweep_dir = cfg_direction;
      if (in_valid && !in_stall) begin
        rotate_into_chain(in_element_value, in_cosine, in_sine, in_first, in_last);
        n_accepted++;
      end
      if (out_valid && !out_stall) begin
        if (rotated_values_due.size() == 0) begin
          errors++;
          if (errors <= PRINT_LIMIT)
            $display("%0t: result with nothing outstanding: value=%h last=%b",
                     $time, out_result_value, out_result_last);
        end else begin
          want = rotated_values_due.pop_front();
          n_checked++;
          if (out_result_value !== want.value) begin
            errors++;
            if (errors <= PRINT_LIMIT)
              $display("%0t: result_value mismatch: expected %h, actual %h",
                       $time, want.value, out_result_value);
          end
          if (out_result_last !== want.last) begin
            errors++;
            if (errors <= PRINT_LIMIT)
              $display("%0t: result_last mismatch: expected %b, actual %b",
                       $time, want.last, out_result_last);
          end
        end
      end
      if (sink_gap > 0) sink_gap--;
      else if (sink_idle_pct != 0 && $urandom_range(1, 100) <= sink_idle_pct)
        sink_gap = $urandom_range(1, 5);
      out_stall <= long_hold || (sink_gap > 0);
    end
  end

  always @(posedge clk) begin
    if (hold_armed) begin
      hold_armed <= 1'b0;
      hold_left = HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left--;
    end
    long_hold <= (hold_left > 0);
  end

  task automatic push_item(input logic [DW-1:0] elem, input int c, input int s,
                           input logic first, input logic last);
    row_item_t it;
    it.element = elem;
    it.cosine = c[CW-1:0];
    it.sine = s[CW-1:0];
    it.first = first;
    it.last = last;
    row_stream.push_back(it);
    n_queued++;
  endtask

  function automatic logic [DW-1:0] rand_element();
    int v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'hffff_ffff;
          default: return 32'h0001_0000;
        endcase
      end
      1, 2, 3: begin
        v = int'($urandom_range(0, 2097152)) - 1048576;
        return v;
      end
      default: return $urandom();
    endcase
  endfunction

  // Mostly within +-1.0, with extremes and the full field range mixed in.
  function automatic int rand_coef();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return int'($urandom_range(0, 131072)) - 65536;
    if (r == 6) begin
      case ($urandom_range(0, 4))
        0: return -131072;
        1: return 131071;
        2: return 65536;
        3: return -65536;
        default: return 0;
      endcase
    end
    return int'($urandom_range(0, 262143)) - 131072;
  endfunction

  // Mostly well-formed rows of random length; the rest are stray items with random flags.
  task automatic add_random_traffic(input int budget);
    int len, k;
    while (budget > 0) begin
      if ($urandom_range(0, 99) < 12) begin
        push_item(rand_element(), rand_coef(), rand_coef(),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        budget--;
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
        for (k = 0; k < len; k++)
          push_item(rand_element(), rand_coef(), rand_coef(), k == 0, k == len - 1);
        budget -= len;
      end
    end
  endtask

  task automatic write_direction(input logic dir);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_direction <= dir;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every item is taken and every result has come back, then lets the
  // pipeline run empty so that a trailing load cannot overlap a register write.
  task automatic settle();
    int waited;
    waited = 0;
    while ((n_accepted != n_queued || rotated_values_due.size() != 0) && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (waited >= DRAIN_LIMIT) begin
      errors++;
      $display("%0t: drain stalled with %0d items and %0d results outstanding",
               $time, n_queued - n_accepted, rotated_values_due.size());
    end
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic set_pace(input int src_pct, input int sink_pct);
    src_idle_pct = src_pct;
    sink_idle_pct = sink_pct;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    write_direction(DIR_FORWARD);
    set_pace(25, 25);
    // A rotation straight after reset works against a zero carry, and the chain
    // carries on without a new first item.
    push_item(32'h0001_0000, 65536, 0, 1'b0, 1'b0);
    push_item(32'hffff_ffff, 32768, 32768, 1'b0, 1'b0);
    // Single-element rows pass through unchanged.
    push_item(32'h7fff_ffff, 0, 0, 1'b1, 1'b1);
    push_item(32'h8000_0000, 0, 0, 1'b1, 1'b1);
    // Coefficients beyond one and extreme elements drive the sums into saturation.
    push_item(32'h7fff_ffff, 0, 0, 1'b1, 1'b0);
    push_item(32'h7fff_ffff, 131071, 131071, 1'b0, 1'b0);
    push_item(32'h8000_0000, -131072, 131071, 1'b0, 1'b0);
    push_item(32'h0000_0001, 32768, -32768, 1'b0, 1'b1);
    // Rotation continues after a last item without a new first.
    push_item(32'h1234_5678, 0, 65536, 1'b0, 1'b0);
    push_item(32'hffff_ffff, 32768, 0, 1'b0, 1'b1);
    // This row is left open so that the direction changes part way through it.
    push_item(32'h0002_0000, 0, 0, 1'b1, 1'b0);
    push_item(32'h0003_0000, 46341, 46341, 1'b0, 1'b0);
    settle();

    write_direction(DIR_BACKWARD);
    push_item(32'h8000_0000, -65536, 65536, 1'b0, 1'b1);
    push_item(32'hffff_0000, 0, 0, 1'b1, 1'b0);
    push_item(32'h7fff_ffff, -131072, -131072, 1'b0, 1'b0);
    push_item(32'h0000_8000, 65536, -65536, 1'b0, 1'b0);
    push_item(32'h0000_0001, 32768, 32768, 1'b0, 1'b1);
    push_item(32'h0000_0000, 0, 0, 1'b1, 1'b1);
    push_item(32'hdead_beef, 1, -1, 1'b1, 1'b0);
    push_item(32'h7fff_ffff, 0, 0, 1'b0, 1'b1);
    settle();

    write_direction(DIR_FORWARD);
    set_pace(30, 30);
    add_random_traffic(110);
    settle();
    write_direction(DIR_BACKWARD);
    set_pace(0, 0);
    add_random_traffic(110);
    settle();
    write_direction(DIR_BACKWARD);
    set_pace(20, 50);
    add_random_traffic(110);
    settle();
    write_direction(DIR_FORWARD);
    set_pace(50, 10);
    add_random_traffic(110);
    settle();
    write_direction(DIR_BACKWARD);
    set_pace(15, 15);
    add_random_traffic(110);
    settle();
    write_direction(DIR_FORWARD);
    set_pace(40, 40);
    add_random_traffic(110);
    settle();

    // The receiver holds off for a long stretch while items keep coming, so the
    // output buffer and the item queue fill and the block stalls its input.
    set_pace(0, 0);
    @(posedge clk);
    hold_armed <= 1'b1;
    add_random_traffic(40);
    settle();

    write_direction(DIR_BACKWARD);
    add_random_traffic(60);
    settle();
    write_direction(DIR_FORWARD);
    add_random_traffic(60);
    settle();

    if (rotated_values_due.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, rotated_values_due.size());
    end
    $display("Ran %0d items in %0d rows: %0d forward and %0d backward rotations.",
             n_accepted, n_rows, n_fwd, n_bwd);
    $display("Checked %0d results, with random idling on both sides and a %0d-cycle hold-off.",
             n_checked, HOLD_CYCLES);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d items and %0d results outstanding",
             n_queued - n_accepted, rotated_values_due.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
